// ===== hdl/ordered_packet_window_table_defines.svh =====
// ----------------------------------------------------------------------------
// ordered packet window table assertion macros
// shared property forms for the checker of the window table
// ----------------------------------------------------------------------------
`ifndef ORDERED_PACKET_WINDOW_TABLE_DEFINES_SVH
`define ORDERED_PACKET_WINDOW_TABLE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define OPWT_ASSERT_IMPLY(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error(msg);

// next-cycle implication, disabled in reset
`define OPWT_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);

`endif

// ===== hdl/opwt_pkg.sv =====
// ----------------------------------------------------------------------------
// opwt_pkg
// types, codes and defaults shared by the ordered packet window table
// ----------------------------------------------------------------------------
package opwt_pkg;

   localparam int DEFAULT_DEPTH = 16;

   // request kinds
   localparam logic [2:0] KIND_INSERT = 3'd0;
   localparam logic [2:0] KIND_APPEND = 3'd1;
   localparam logic [2:0] KIND_REMOVE = 3'd2;
   localparam logic [2:0] KIND_ACK    = 3'd3;
   localparam logic [2:0] KIND_SLIDE  = 3'd4;

   // result status codes
   localparam logic [1:0] ST_DONE  = 2'd0;
   localparam logic [1:0] ST_DUP   = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;
   localparam logic [1:0] ST_EMPTY = 2'd3;

   // commands broadcast to the cell row
   localparam logic [2:0] CMD_HOLD   = 3'd0;
   localparam logic [2:0] CMD_SHIFT  = 3'd1;
   localparam logic [2:0] CMD_INSERT = 3'd2;
   localparam logic [2:0] CMD_APPEND = 3'd3;
   localparam logic [2:0] CMD_ACK    = 3'd4;

   typedef struct packed {
      logic [2:0]         kind;
      logic signed [31:0] seq_key;
      logic [15:0]        packet_handle;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic               slid_any;
      logic [4:0]         entry_count;
      logic               head_valid;
      logic signed [31:0] head_key;
      logic [15:0]        head_handle;
   } rsp_type;

   // one stored entry
   typedef struct packed {
      logic signed [31:0] key;
      logic [15:0]        handle;
      logic               acked;
   } entry_type;

   // prefix flags passed from cell to cell
   typedef struct packed {
      logic hit_seen;
      logic eq_seen;
      logic dup;
   } scan_type;

   // command broadcast to every cell
   typedef struct packed {
      logic [2:0]         op;
      logic               capture;
      logic               any_hit;
      logic signed [31:0] cmp_key;
      logic signed [31:0] key;
      logic [15:0]        handle;
   } cell_cmd_type;

endpackage

// ===== hdl/opwt_cell.sv =====
// ----------------------------------------------------------------------------
// opwt_cell
// one table position: holds an entry, compares it and shifts with neighbours
// ----------------------------------------------------------------------------
module opwt_cell #(
   parameter int DEPTH = opwt_pkg::DEFAULT_DEPTH,
   parameter int INDEX = 0
) (
   input  logic                         clock,
   input  opwt_pkg::cell_cmd_type       cmd,
   input  logic [$clog2(DEPTH+1)-1:0]   held_count,
   input  opwt_pkg::entry_type          from_lo,
   input  opwt_pkg::entry_type          from_hi,
   input  opwt_pkg::scan_type           scan_in,
   output opwt_pkg::scan_type           scan_out,
   output opwt_pkg::entry_type          cur_entry,
   output opwt_pkg::entry_type          next_entry
);
   import opwt_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);

   entry_type entry_ff, entry_in;
   logic      occ_ff, eq_ff, gt_ff;
   logic      occ_in, eq_in, gt_in;
   logic      is_tail, is_first;
   entry_type new_entry;

   // position against the fill level
   assign occ_in  = CW'(INDEX) < held_count;
   assign is_tail = CW'(INDEX) == held_count;

   // compare against the offered key, captured with the transaction
   assign eq_in = occ_in && (entry_ff.key == cmd.cmp_key);
   assign gt_in = occ_in && ($signed(entry_ff.key) > $signed(cmd.cmp_key));

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         occ_ff <= occ_in;
         eq_ff  <= eq_in;
         gt_ff  <= gt_in;
      end
   end

   // prefix flags down the row
   assign is_first          = (eq_ff | gt_ff) & ~scan_in.hit_seen;
   assign scan_out.hit_seen = scan_in.hit_seen | eq_ff | gt_ff;
   assign scan_out.eq_seen  = scan_in.eq_seen | eq_ff;
   assign scan_out.dup      = scan_in.dup | (eq_ff & ~scan_in.hit_seen);

   assign new_entry = '{key: cmd.key, handle: cmd.handle, acked: 1'b0};

   // entry update
   always_comb begin
      entry_in = entry_ff;
      unique case (cmd.op)
         CMD_HOLD: entry_in = entry_ff;
         CMD_SHIFT: entry_in = from_hi;
         CMD_INSERT: begin
            if (cmd.any_hit ? is_first : is_tail) begin
               entry_in = new_entry;
            end else if (cmd.any_hit && scan_in.hit_seen) begin
               entry_in = from_lo;
            end
         end
         CMD_APPEND: begin
            if (is_tail) begin
               entry_in = new_entry;
            end
         end
         CMD_ACK: begin
            if (occ_ff && !(scan_in.eq_seen | eq_ff)) begin
               entry_in.acked = 1'b1;
            end
         end
         default: entry_in = entry_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign cur_entry  = entry_ff;
   assign next_entry = entry_in;

endmodule

// ===== hdl/ordered_packet_window_table.sv =====
// ----------------------------------------------------------------------------
// ordered_packet_window_table
// Retransmission window held in a row of cells, sorted by inserts; appends
// go to the tail. Every cell compares its entry with the offered key in the
// cycle a transaction is accepted; the execute state then resolves the
// first match along the row and inserts, appends, removes or acks in one
// step once the output register is free. A slide removes one acked head
// entry per cycle while the output register is free, as the row shifts
// down by one cell. The result sits in an output register, and a new
// transaction is accepted while it waits to be taken.
// ----------------------------------------------------------------------------
module ordered_packet_window_table #(
   parameter int DEPTH = opwt_pkg::DEFAULT_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  opwt_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output opwt_pkg::rsp_type rsp_payload
);
   import opwt_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_EXEC = 1'b1;

   logic               state_ff, state_in;
   logic [CW-1:0]      count_ff, count_in;
   logic               slid_ff, slid_in;
   logic               rsp_valid_ff;
   rsp_type            rsp_data_ff;
   logic [2:0]         kind_ff;
   logic signed [31:0] key_ff;
   logic [15:0]        handle_ff;

   logic               req_accept, rsp_free, full, finish;
   logic [1:0]         status;
   cell_cmd_type       cmd;

   entry_type entry_cur [DEPTH];
   entry_type entry_nxt [DEPTH];
   entry_type lo_src    [DEPTH];
   entry_type hi_src    [DEPTH];
   scan_type  scan_chain [DEPTH+1];

   // handshake
   assign req_accept = req_valid && (state_ff == S_IDLE);
   assign req_stall  = (state_ff != S_IDLE);
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign full       = (count_ff == CW'(DEPTH));

   // cell row
   assign scan_chain[0] = '0;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_lo_end
         assign lo_src[i] = '0;
      end else begin : g_lo_nb
         assign lo_src[i] = entry_cur[i-1];
      end
      if (i == DEPTH - 1) begin : g_hi_end
         assign hi_src[i] = '0;
      end else begin : g_hi_nb
         assign hi_src[i] = entry_cur[i+1];
      end

      opwt_cell #(
         .DEPTH (DEPTH),
         .INDEX (i)
      ) u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .held_count (count_ff),
         .from_lo    (lo_src[i]),
         .from_hi    (hi_src[i]),
         .scan_in    (scan_chain[i]),
         .scan_out   (scan_chain[i+1]),
         .cur_entry  (entry_cur[i]),
         .next_entry (entry_nxt[i])
      );
   end

   // sequencer
   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      slid_in     = slid_ff;
      finish      = 1'b0;
      status      = ST_DONE;
      cmd.op      = CMD_HOLD;
      cmd.capture = req_accept;
      cmd.any_hit = scan_chain[DEPTH].hit_seen;
      cmd.cmp_key = req_payload.seq_key;
      cmd.key     = key_ff;
      cmd.handle  = handle_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_EXEC;
               slid_in  = 1'b0;
            end
         end
         S_EXEC: begin
            if (rsp_free) begin
               finish = 1'b1;
               unique case (kind_ff)
                  KIND_INSERT: begin
                     if (scan_chain[DEPTH].dup) begin
                        status = ST_DUP;
                     end else if (full) begin
                        status = ST_FULL;
                     end else begin
                        cmd.op   = CMD_INSERT;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  KIND_APPEND: begin
                     if (full) begin
                        status = ST_FULL;
                     end else begin
                        cmd.op   = CMD_APPEND;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  KIND_REMOVE: begin
                     if (count_ff == '0) begin
                        status = ST_EMPTY;
                     end else begin
                        cmd.op   = CMD_SHIFT;
                        count_in = count_ff - CW'(1);
                     end
                  end
                  KIND_ACK: cmd.op = CMD_ACK;
                  KIND_SLIDE: begin
                     // drop one acked head entry per cycle while the output register is free
                     if (count_ff != '0 && entry_cur[0].acked) begin
                        cmd.op   = CMD_SHIFT;
                        count_in = count_ff - CW'(1);
                        slid_in  = 1'b1;
                        finish   = 1'b0;
                     end else if (count_ff == '0 && !slid_ff) begin
                        status = ST_EMPTY;
                     end
                  end
                  default: status = ST_DONE;
               endcase
            end
            if (finish) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         slid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         slid_ff  <= slid_in;
      end
   end

   // transaction fields held while it executes
   always_ff @(posedge clock) begin
      if (req_accept) begin
         kind_ff   <= req_payload.kind;
         key_ff    <= req_payload.seq_key;
         handle_ff <= req_payload.packet_handle;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_data_ff.status      <= status;
         rsp_data_ff.slid_any    <= slid_in;
         rsp_data_ff.entry_count <= 5'(count_in);
         rsp_data_ff.head_valid  <= (count_in != '0);
         rsp_data_ff.head_key    <= (count_in != '0) ? entry_nxt[0].key : '0;
         rsp_data_ff.head_handle <= (count_in != '0) ? entry_nxt[0].handle : '0;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

endmodule

// ===== hdl/opwt_checker.sv =====
// ----------------------------------------------------------------------------
// opwt_checker
// port-level checks on the results of the ordered packet window table
// ----------------------------------------------------------------------------
`include "ordered_packet_window_table_defines.svh"

module opwt_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input opwt_pkg::rsp_type rsp_payload
);
   import opwt_pkg::*;

   // an empty table reports no head and a zero count
   `OPWT_ASSERT_IMPLY(a_empty_head, clock, reset, rsp_valid && !rsp_payload.head_valid, rsp_payload.entry_count == 5'd0 && rsp_payload.head_key == '0 && rsp_payload.head_handle == '0, "empty result carries head data")

   // a dropped insert or append means a full table and no slide
   `OPWT_ASSERT_IMPLY(a_full_head, clock, reset, rsp_valid && rsp_payload.status == ST_FULL, rsp_payload.head_valid && !rsp_payload.slid_any, "full status without a head entry")

   // a slide that removed entries completes as done
   `OPWT_ASSERT_IMPLY(a_slid_done, clock, reset, rsp_valid && rsp_payload.slid_any, rsp_payload.status == ST_DONE, "slide flag with a non-done status")

   // a stalled result holds
   `OPWT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_payload), "stalled result changed")

   // one transaction at a time: the input stalls right after an accept
   `OPWT_ASSERT_NEXT(a_req_busy, clock, reset, req_valid && !req_stall, req_stall, "request accepted while busy")

endmodule

bind ordered_packet_window_table opwt_checker u_opwt_checker (.*);

// ===== sim/ordered_packet_window_table_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_packet_window_table_tb
// Self-checking bench for the packet window table. A directed table covers
// empty-table cases, signed key extremes, duplicates, the full table, acks
// and slides. A long random run follows, mixing fill, churn and drain
// phases. Results are scored against a behavioural model of the window or,
// for typed directed rows, their own result, with bursty requests and a patterned result stall.
// ----------------------------------------------------------------------------
module ordered_packet_window_table_tb;
   import opwt_pkg::*;

   localparam int DEPTH        = opwt_pkg::DEFAULT_DEPTH;
   localparam int RANDOM_ITEMS = 1820;
   localparam int DRAIN_CYCLES = 40;
   localparam int REPORT_LIMIT = 10;

   // request kinds
   localparam logic [2:0] OP_INSERT    = KIND_INSERT;
   localparam logic [2:0] OP_APPEND    = KIND_APPEND;
   localparam logic [2:0] OP_REMOVE    = KIND_REMOVE;
   localparam logic [2:0] OP_ACK       = KIND_ACK;
   localparam logic [2:0] OP_SLIDE     = KIND_SLIDE;
   localparam logic [2:0] OP_UNUSED_LO = 3'd5;
   localparam logic [2:0] OP_UNUSED_HI = 3'd7;

   localparam logic signed [31:0] KEY_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;

   typedef enum logic [1:0] {MIX_FILL, MIX_CHURN, MIX_DRAIN} mix_type;

   typedef struct {
      req_type req;
      int      repeats;
      bit      typed;
      rsp_type want;
   } stim_row_type;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_payload;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_payload;

   // window model state
   logic signed [31:0] win_key    [DEPTH];
   logic [15:0]        win_handle [DEPTH];
   logic               win_acked  [DEPTH];
   int                 win_count = 0;

   rsp_type      expected_results [$];
   int           mismatch_count = 0;
   int           result_index = 0;
   int           burst_left = 0;
   stim_row_type directed [21];

   ordered_packet_window_table #(
      .DEPTH(DEPTH)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload)
   );

   // clock
   initial clock = 1'b0;
   always #5 clock = ~clock;

   // open a gap in the window and store a fresh unacked entry
   function automatic void place_entry(input int pos, input logic signed [31:0] key,
                                       input logic [15:0] handle);
      int i;
      for (i = win_count; i > pos; i--) begin
         win_key[i]    = win_key[i - 1];
         win_handle[i] = win_handle[i - 1];
         win_acked[i]  = win_acked[i - 1];
      end
      win_key[pos]    = key;
      win_handle[pos] = handle;
      win_acked[pos]  = 1'b0;
      win_count++;
   endfunction

   // drop n entries from the head
   function automatic void shift_out(input int n);
      int i;
      for (i = 0; i + n < win_count; i++) begin
         win_key[i]    = win_key[i + n];
         win_handle[i] = win_handle[i + n];
         win_acked[i]  = win_acked[i + n];
      end
      win_count -= n;
   endfunction

   // apply one transaction to the window model, return the result it gives
   function automatic rsp_type predict_window_result(input req_type r);
      rsp_type res;
      int      pos;
      int      n;
      int      i;
      bit      dup;
      res = '0;
      res.status = ST_DONE;
      case (r.kind)
         OP_INSERT: begin
            pos = win_count;
            dup = 1'b0;
            // a duplicate only counts if met before the first larger key
            for (i = 0; i < win_count; i++) begin
               if (win_key[i] == r.seq_key) begin
                  dup = 1'b1;
                  break;
               end
               if ($signed(win_key[i]) > $signed(r.seq_key)) begin
                  pos = i;
                  break;
               end
            end
            if (dup) begin
               res.status = ST_DUP;
            end else if (win_count >= DEPTH) begin
               res.status = ST_FULL;
            end else begin
               place_entry(pos, r.seq_key, r.packet_handle);
            end
         end
         OP_APPEND: begin
            if (win_count >= DEPTH) begin
               res.status = ST_FULL;
            end else begin
               place_entry(win_count, r.seq_key, r.packet_handle);
            end
         end
         OP_REMOVE: begin
            if (win_count == 0) begin
               res.status = ST_EMPTY;
            end else begin
               shift_out(1);
            end
         end
         OP_ACK: begin
            // cumulative: everything ahead of the matching key
            for (i = 0; i < win_count && win_key[i] != r.seq_key; i++) begin
               win_acked[i] = 1'b1;
            end
         end
         OP_SLIDE: begin
            if (win_count == 0) begin
               res.status = ST_EMPTY;
            end else begin
               n = 0;
               while (n < win_count && win_acked[n]) begin
                  n++;
               end
               if (n > 0) begin
                  res.slid_any = 1'b1;
                  shift_out(n);
               end
            end
         end
         default: begin
         end
      endcase
      res.entry_count = 5'(win_count);
      res.head_valid  = (win_count > 0);
      if (win_count > 0) begin
         res.head_key    = win_key[0];
         res.head_handle = win_handle[0];
      end
      return res;
   endfunction

   function automatic stim_row_type directed_row(
      input logic [2:0] kind, input logic signed [31:0] key, input logic [15:0] handle,
      input int repeats, input bit typed, input logic [1:0] status, input int count,
      input logic signed [31:0] head_key, input logic [15:0] head_handle);
      stim_row_type row;
      row.req.kind            = kind;
      row.req.seq_key         = key;
      row.req.packet_handle   = handle;
      row.repeats             = repeats;
      row.typed               = typed;
      row.want.status         = status;
      row.want.slid_any       = 1'b0;
      row.want.entry_count    = 5'(count);
      row.want.head_valid     = (count > 0);
      row.want.head_key       = head_key;
      row.want.head_handle    = head_handle;
      return row;
   endfunction

   // offer one transaction, book its expected result once taken
   task automatic send_request(input req_type r, input bit typed, input rsp_type typed_rsp);
      rsp_type predicted;
      int      gap;
      req_payload <= r;
      req_valid   <= 1'b1;
      do @(posedge clock); while (req_stall);
      predicted = predict_window_result(r);
      expected_results.push_back(typed ? typed_rsp : predicted);
      // bursts of random length with random gaps between them
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // hold off requests until every outstanding result is back
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   // result stall on its own changing pattern
   int stall_left = 0;
   int stall_mode = 0;
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_left = $urandom_range(10, 60);
      end
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= $urandom_range(0, 1);
         default: rsp_stall <= ((stall_left % 16) < 10);
      endcase
      stall_left--;
   end

   // result scoreboard
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
               $display("result %0d: unexpected transaction, status %0d count %0d",
                        result_index, rsp_payload.status, rsp_payload.entry_count);
            end
         end else begin
            want = expected_results.pop_front();
            if (rsp_payload !== want) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT) begin
                  $display("result %0d mismatch (exp/act): status %0d/%0d slid %0d/%0d",
                           result_index, want.status, rsp_payload.status,
                           want.slid_any, rsp_payload.slid_any);
                  $display("   count %0d/%0d head_valid %0d/%0d key %0d/%0d handle %h/%h",
                           want.entry_count, rsp_payload.entry_count,
                           want.head_valid, rsp_payload.head_valid,
                           want.head_key, rsp_payload.head_key,
                           want.head_handle, rsp_payload.head_handle);
               end
            end
         end
         result_index++;
      end
   end

   // stimulus
   initial begin
      req_type            r;
      rsp_type            none;
      mix_type            mix;
      int                 mix_left;
      int                 roll;
      int                 t_ins, t_app, t_ack, t_slide, t_rem;
      int                 k;
      int                 j;
      logic signed [31:0] window_base;

      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      none        = '0;

      // empty-table cases, signed extremes, duplicates, full table, ack and slide
      directed[0]  = directed_row(OP_SLIDE, 0, 0, 1, 1, ST_EMPTY, 0, 0, 0);
      directed[1]  = directed_row(OP_REMOVE, 0, 0, 1, 1, ST_EMPTY, 0, 0, 0);
      directed[2]  = directed_row(OP_ACK, 0, 0, 1, 1, ST_DONE, 0, 0, 0);
      directed[3]  = directed_row(OP_UNUSED_HI, KEY_MAX, 16'hFFFF, 1, 1, ST_DONE, 0, 0, 0);
      directed[4]  = directed_row(OP_INSERT, KEY_MAX, 16'hFFFF, 1, 1, ST_DONE, 1,
                                  KEY_MAX, 16'hFFFF);
      directed[5]  = directed_row(OP_INSERT, KEY_MIN, 16'h0000, 1, 1, ST_DONE, 2,
                                  KEY_MIN, 16'h0000);
      directed[6]  = directed_row(OP_INSERT, 0, 16'h1234, 1, 0, ST_DONE, 0, 0, 0);
      directed[7]  = directed_row(OP_INSERT, 0, 16'h4321, 1, 0, ST_DONE, 0, 0, 0);
      directed[8]  = directed_row(OP_APPEND, -5, 16'h5555, 1, 0, ST_DONE, 0, 0, 0);
      // same key sits past a larger one, so this is not a duplicate
      directed[9]  = directed_row(OP_INSERT, -5, 16'hAAAA, 1, 0, ST_DONE, 0, 0, 0);
      directed[10] = directed_row(OP_APPEND, 200, 16'h0F0F, 11, 0, ST_DONE, 0, 0, 0);
      // duplicate reported even though the table is full
      directed[11] = directed_row(OP_INSERT, 0, 16'h0001, 1, 0, ST_DONE, 0, 0, 0);
      directed[12] = directed_row(OP_INSERT, 1, 16'h0002, 1, 0, ST_DONE, 0, 0, 0);
      directed[13] = directed_row(OP_APPEND, 3, 16'h0003, 1, 0, ST_DONE, 0, 0, 0);
      directed[14] = directed_row(OP_ACK, 0, 0, 1, 0, ST_DONE, 0, 0, 0);
      directed[15] = directed_row(OP_SLIDE, 0, 0, 1, 0, ST_DONE, 0, 0, 0);
      directed[16] = directed_row(OP_REMOVE, 0, 0, 1, 0, ST_DONE, 0, 0, 0);
      // no key matches, so every entry is acked
      directed[17] = directed_row(OP_ACK, 12345, 0, 1, 0, ST_DONE, 0, 0, 0);
      directed[18] = directed_row(OP_UNUSED_LO, 77, 16'h7777, 1, 0, ST_DONE, 0, 0, 0);
      directed[19] = directed_row(OP_SLIDE, 0, 0, 1, 0, ST_DONE, 0, 0, 0);
      directed[20] = directed_row(OP_SLIDE, 0, 0, 1, 0, ST_DONE, 0, 0, 0);

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part
      foreach (directed[k]) begin
         for (j = 0; j < directed[k].repeats; j++) begin
            send_request(directed[k].req, directed[k].typed, directed[k].want);
         end
      end
      wait_drained();

      // random part: phases that fill, churn or drain the window
      window_base = $urandom;
      mix         = MIX_FILL;
      mix_left    = 0;
      for (k = 0; k < RANDOM_ITEMS; k++) begin
         if (k == RANDOM_ITEMS / 2) begin
            wait_drained();
         end
         if (mix_left == 0) begin
            mix      = mix_type'($urandom_range(0, 2));
            mix_left = $urandom_range(20, 80);
         end
         mix_left--;
         case (mix)
            MIX_FILL: begin
               t_ins = 55; t_app = 75; t_ack = 85; t_slide = 93; t_rem = 98;
            end
            MIX_CHURN: begin
               t_ins = 30; t_app = 45; t_ack = 65; t_slide = 80; t_rem = 98;
            end
            default: begin
               t_ins = 12; t_app = 17; t_ack = 47; t_slide = 77; t_rem = 98;
            end
         endcase
         roll = $urandom_range(0, 99);
         r.kind = (roll < t_ins)   ? OP_INSERT :
                  (roll < t_app)   ? OP_APPEND :
                  (roll < t_ack)   ? OP_ACK :
                  (roll < t_slide) ? OP_SLIDE :
                  (roll < t_rem)   ? OP_REMOVE :
                  3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
         r.packet_handle = 16'($urandom);
         // keys mostly from a narrow window so duplicates and ordering matter
         roll = $urandom_range(0, 99);
         if (r.kind == OP_ACK && win_count > 0 && roll < 60) begin
            r.seq_key = win_key[$urandom_range(0, win_count - 1)];
         end else if (roll < 80) begin
            r.seq_key = window_base + $signed(32'($urandom_range(0, 39)));
         end else if (roll < 92) begin
            r.seq_key = $urandom;
         end else if (roll < 96) begin
            r.seq_key = $urandom_range(0, 1) ? KEY_MAX : KEY_MIN;
         end else begin
            // move the window on, now and then to just under the signed wrap
            if ($urandom_range(0, 3) == 0) begin
               window_base = KEY_MAX - 32'sd24;
            end else begin
               window_base = window_base + $signed(32'($urandom_range(1, 64)));
            end
            r.seq_key = window_base;
         end
         send_request(r, 1'b0, none);
      end

      // end of run
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("ordered_packet_window_table regression: pass");
      end else begin
         $display("ordered_packet_window_table regression: fail");
      end
      $finish;
   end

   // watchdog
   initial begin
      #(5_000_000);
      $display("ordered_packet_window_table regression: fail");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/opwt_pkg.sv
hdl/opwt_cell.sv
hdl/ordered_packet_window_table.sv
hdl/opwt_checker.sv
sim/ordered_packet_window_table_tb.sv
